@@ design/sfpp_pkg.sv @@
// ----------------------------------------------------------------------------
// sfpp_pkg: shared types and constants for the sync framed packet parser
// Field widths, register indexes, reset values and the result word layout.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sfpp_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned SumW    = 16;
  localparam int unsigned CfgIdxW = 2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgSyncFirst  = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgSyncSecond = 2'd1;

  localparam logic [ByteW-1:0] SyncFirstRst  = 8'd170;
  localparam logic [ByteW-1:0] SyncSecondRst = 8'd85;

  typedef struct packed {
    logic             payload_valid;
    logic [ByteW-1:0] payload_byte;
    logic [ByteW-1:0] payload_index;
    logic             frame_done;
    logic             checksum_ok;
    logic [ByteW-1:0] frame_command;
    logic [ByteW-1:0] frame_length;
  } result_t;

  // handshake between the core pipeline and the output register
  typedef struct packed {
    logic load;
    logic take;
  } out_ctrl_t;

endpackage

@@ design/sfpp_if.sv @@
// ----------------------------------------------------------------------------
// sfpp_rx_if / sfpp_res_if: valid/ready channels of the parser
// One word moves when valid and ready are both high at a rising edge.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface sfpp_rx_if;
  logic                      valid;
  logic                      ready;
  logic [sfpp_pkg::ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface sfpp_res_if;
  logic                      valid;
  logic                      ready;
  logic                      payload_valid;
  logic [sfpp_pkg::ByteW-1:0] payload_byte;
  logic [sfpp_pkg::ByteW-1:0] payload_index;
  logic                      frame_done;
  logic                      checksum_ok;
  logic [sfpp_pkg::ByteW-1:0] frame_command;
  logic [sfpp_pkg::ByteW-1:0] frame_length;

  modport source (
    output valid, output payload_valid, output payload_byte, output payload_index,
    output frame_done, output checksum_ok, output frame_command, output frame_length,
    input ready
  );
  modport sink (
    input valid, input payload_valid, input payload_byte, input payload_index,
    input frame_done, input checksum_ok, input frame_command, input frame_length,
    output ready
  );
endinterface

@@ design/sfpp_core.sv @@
// ----------------------------------------------------------------------------
// sfpp_core: frame state and per-byte decode
// Sync hunt, header capture, payload streaming and checksum compare.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfpp_core (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       step_i,
  input  logic [sfpp_pkg::ByteW-1:0] byte_i,
  input  logic [sfpp_pkg::ByteW-1:0] sync_first_i,
  input  logic [sfpp_pkg::ByteW-1:0] sync_second_i,
  output sfpp_pkg::result_t          res_o
);

  logic                      sync_half_q, sync_half_d;
  logic                      sync_full_q, sync_full_d;
  logic                      have_cmd_q, have_cmd_d;
  logic                      have_len_q, have_len_d;
  logic                      have_chk_hi_q, have_chk_hi_d;
  logic [sfpp_pkg::ByteW-1:0] cmd_q, cmd_d;
  logic [sfpp_pkg::ByteW-1:0] len_q, len_d;
  logic [sfpp_pkg::ByteW-1:0] count_q, count_d;
  logic [sfpp_pkg::ByteW-1:0] chk_hi_q, chk_hi_d;
  logic [sfpp_pkg::SumW-1:0]  sum_q, sum_d;
  logic [sfpp_pkg::SumW-1:0]  byte_ext;
  logic [sfpp_pkg::SumW-1:0]  received;

  assign byte_ext = {{(sfpp_pkg::SumW-sfpp_pkg::ByteW){1'b0}}, byte_i};
  assign received = {chk_hi_q, byte_i};

  always_comb begin
    sync_half_d   = sync_half_q;
    sync_full_d   = sync_full_q;
    have_cmd_d    = have_cmd_q;
    have_len_d    = have_len_q;
    have_chk_hi_d = have_chk_hi_q;
    cmd_d         = cmd_q;
    len_d         = len_q;
    count_d       = count_q;
    chk_hi_d      = chk_hi_q;
    sum_d         = sum_q;
    res_o         = '0;

    if (!sync_half_q || !sync_full_q) begin
      // hunting: a repeated first sync byte keeps the half match
      if (byte_i == sync_first_i) begin
        sync_half_d = 1'b1;
      end else if (sync_half_q && byte_i == sync_second_i) begin
        sync_full_d = 1'b1;
      end else begin
        sync_half_d = 1'b0;
      end
    end else if (!have_cmd_q) begin
      have_cmd_d = 1'b1;
      cmd_d      = byte_i;
      sum_d      = {{(sfpp_pkg::SumW-sfpp_pkg::ByteW){1'b0}}, sync_first_i}
                 + {{(sfpp_pkg::SumW-sfpp_pkg::ByteW){1'b0}}, sync_second_i}
                 + byte_ext;
    end else if (!have_len_q) begin
      have_len_d = 1'b1;
      len_d      = byte_i;
      count_d    = '0;
      sum_d      = sum_q + byte_ext;
    end else if (count_q < len_q) begin
      res_o.payload_valid = 1'b1;
      res_o.payload_byte  = byte_i;
      res_o.payload_index = count_q;
      count_d             = count_q + 8'd1;
      sum_d               = sum_q + byte_ext;
    end else if (!have_chk_hi_q) begin
      have_chk_hi_d = 1'b1;
      chk_hi_d      = byte_i;
    end else begin
      res_o.frame_done  = 1'b1;
      res_o.checksum_ok = (received == sum_q);
      have_cmd_d        = 1'b0;
      have_len_d        = 1'b0;
      have_chk_hi_d     = 1'b0;
      sync_half_d       = 1'b0;
      sync_full_d       = 1'b0;
    end

    res_o.frame_command = cmd_d;
    res_o.frame_length  = len_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_half_q   <= 1'b0;
      sync_full_q   <= 1'b0;
      have_cmd_q    <= 1'b0;
      have_len_q    <= 1'b0;
      have_chk_hi_q <= 1'b0;
      cmd_q         <= '0;
      len_q         <= '0;
      count_q       <= '0;
      chk_hi_q      <= '0;
      sum_q         <= '0;
    end else if (step_i) begin
      sync_half_q   <= sync_half_d;
      sync_full_q   <= sync_full_d;
      have_cmd_q    <= have_cmd_d;
      have_len_q    <= have_len_d;
      have_chk_hi_q <= have_chk_hi_d;
      cmd_q         <= cmd_d;
      len_q         <= len_d;
      count_q       <= count_d;
      chk_hi_q      <= chk_hi_d;
      sum_q         <= sum_d;
    end
  end

endmodule

@@ design/sfpp_out_stage.sv @@
// ----------------------------------------------------------------------------
// sfpp_out_stage: result register
// Holds one decoded result word until the sink takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sfpp_out_stage (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sfpp_pkg::out_ctrl_t ctrl_i,
  input  sfpp_pkg::result_t   res_i,
  output logic               valid_o,
  output logic               free_o,
  output sfpp_pkg::result_t   res_o
);

  logic              valid_q, valid_d;
  sfpp_pkg::result_t res_q;

  // free when empty or when the word held now leaves this cycle
  assign free_o  = !valid_q || ctrl_i.take;
  assign valid_d = ctrl_i.load || (valid_q && !ctrl_i.take);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      res_q <= res_i;
    end
  end

  assign valid_o = valid_q;
  assign res_o   = res_q;

endmodule

@@ design/sync_framed_packet_parser.sv @@
// ----------------------------------------------------------------------------
// sync_framed_packet_parser: streaming parser for sync-framed byte packets
// Hunts for a two-byte sync, then decodes command, length, payload, checksum.
//
//   channel  dir  payload                                    role
//   rx_i     in   rx_byte                                    received bytes
//   res_o    out  payload_valid/byte/index, frame_done,      one word per byte
//                 checksum_ok, frame_command, frame_length
//   cfg_*    in   cfg_idx_i, cfg_data_i                      sync byte setup
//
// One byte per cycle sustained while res_o.ready stays high; an accepted byte
// passes through the input register, then the result register. Frame state is
// updated as a byte moves from the input register into the result register.
// Reset clears all frame state and restores the sync bytes to 0xAA / 0x55.
// A stalled sink holds the result word; rx_i.ready drops only when both the
// input and result registers are full and the result is not being taken.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sync_framed_packet_parser (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [sfpp_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [sfpp_pkg::ByteW-1:0]     cfg_data_i,
  sfpp_rx_if.sink                        rx_i,
  sfpp_res_if.source                     res_o
);

  logic [sfpp_pkg::ByteW-1:0] sync_first_q;
  logic [sfpp_pkg::ByteW-1:0] sync_second_q;
  logic                       in_valid_q;
  logic [sfpp_pkg::ByteW-1:0] in_byte_q;
  logic                       step;
  logic                       out_valid;
  logic                       out_free;
  sfpp_pkg::out_ctrl_t        out_ctrl;
  sfpp_pkg::result_t          core_res;
  sfpp_pkg::result_t          out_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sync_first_q  <= sfpp_pkg::SyncFirstRst;
      sync_second_q <= sfpp_pkg::SyncSecondRst;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        sfpp_pkg::CfgSyncFirst:  sync_first_q  <= cfg_data_i;
        sfpp_pkg::CfgSyncSecond: sync_second_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // input register
  assign step       = in_valid_q && out_free;
  assign rx_i.ready = !in_valid_q || out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx_i.ready) begin
      in_valid_q <= rx_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_i.valid && rx_i.ready) begin
      in_byte_q <= rx_i.rx_byte;
    end
  end

  sfpp_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (step),
    .byte_i        (in_byte_q),
    .sync_first_i  (sync_first_q),
    .sync_second_i (sync_second_q),
    .res_o         (core_res)
  );

  assign out_ctrl = '{load: step, take: out_valid && res_o.ready};

  sfpp_out_stage u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (out_ctrl),
    .res_i   (core_res),
    .valid_o (out_valid),
    .free_o  (out_free),
    .res_o   (out_res)
  );

  assign res_o.valid         = out_valid;
  assign res_o.payload_valid = out_res.payload_valid;
  assign res_o.payload_byte  = out_res.payload_byte;
  assign res_o.payload_index = out_res.payload_index;
  assign res_o.frame_done    = out_res.frame_done;
  assign res_o.checksum_ok   = out_res.checksum_ok;
  assign res_o.frame_command = out_res.frame_command;
  assign res_o.frame_length  = out_res.frame_length;

  // a checksum verdict only comes with the end of a frame
  a_ok_needs_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.checksum_ok |-> res_o.frame_done)
    else $error("checksum_ok without frame_done");

  // payload index stays inside the declared length
  a_index_in_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.payload_valid |-> res_o.payload_index < res_o.frame_length)
    else $error("payload index beyond frame length");

  // a byte is either payload or the frame end, never both
  a_payload_not_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_o.valid && res_o.payload_valid |-> !res_o.frame_done)
    else $error("payload byte flagged as frame end");

  // a byte in the input register reaches the result register once it is free
  a_step_loads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_free |=> out_valid)
    else $error("decoded byte lost between stages");

endmodule
